/* sv/hduart_pkg.sv */
// hduart_pkg: shared types and constants for the half-duplex 8n1 serial core
// holds the input and result word layouts, action codes and register indexes
// no dependencies
`default_nettype none

package hduart_pkg;

    // field widths fixed by the word layout
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned CFG_IDX_W = 1;

    // action codes carried in the input word
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE = 1'b1;

    // register reset values
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST   = 10'd104;
    localparam logic [PERIOD_W-1:0] FIRST_SAMPLE_RST = 10'd156;

    // frame shape
    localparam logic [3:0] DATA_BITS = 4'd8;

    // input word
    typedef struct packed {
        t_action     action;
        logic [3:0]  buf_index;
        logic [7:0]  buf_data;
        logic [4:0]  send_count;
        logic        rx_level;
    } t_in_word;

    // result word
    typedef struct packed {
        logic        tx_line;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        tx_busy;
        logic        rx_busy;
    } t_out_word;

endpackage

`default_nettype wire

/* sv/hduart_store.sv */
// hduart_store: transmit byte buffer, one write port and one registered read port
// depends on nothing; contents are undefined until written
`default_nettype none

module hduart_store #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered: data valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/half_duplex_uart_8n1_core.sv */
// half_duplex_uart_8n1_core: half-duplex 8n1 serial port paced by timer-tick words
// depends on hduart_pkg and hduart_store
//
// Usage: every input word is one action: a transmit buffer write, a send
// request for a burst of 1..16 bytes starting at slot 0, or a timer tick
// that carries the sampled receive line level, or a no-op. Each accepted word gives
// exactly one result word with the transmit line level, the received-byte
// flag, the last received byte and the two busy flags.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Configuration (bit period, first sample delay) is written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write it only while no word
// is in flight; the block does not enforce this. A word accepted into the
// read stage, which registers the buffer read, then takes the state update
// into the output register. Throughput: one word per cycle while not stalled,
// set by the read-modify-write of the port state around the buffer read port.
// When the downstream side stalls, the result holds, the word behind it
// waits in the read stage and o_in_stall rises until the result is taken.
// Reset (synchronous, active low) returns the port to idle with the line
// high and the registers at 104 and 156 ticks; the buffer is not cleared.
`default_nettype none

module half_duplex_uart_8n1_core #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire hduart_pkg::t_in_word                i_in_word,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output hduart_pkg::t_out_word                    o_out_word,
    input  wire logic                                i_cfg_we,
    input  wire logic [hduart_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [hduart_pkg::PERIOD_W-1:0]     i_cfg_data
);

    localparam int unsigned ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned LEN_CAP = (BUFFER_DEPTH < 31) ? BUFFER_DEPTH : 31;
    localparam logic [4:0]  LEN_MAX = 5'(LEN_CAP);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } t_mode;

    // configuration
    logic [hduart_pkg::PERIOD_W-1:0] r_bit_period;
    logic [hduart_pkg::PERIOD_W-1:0] r_first_delay;

    // read stage
    logic                 r_a_valid;
    hduart_pkg::t_in_word r_a_word;
    logic [7:0]           rd_data;

    // port state
    t_mode                           r_mode,       n_mode;
    logic [hduart_pkg::PERIOD_W-1:0] r_tick,       n_tick;
    logic                            r_prev_rx,    n_prev_rx;
    logic [7:0]                      r_tx_shift,   n_tx_shift;
    logic [3:0]                      r_tx_bits,    n_tx_bits;
    logic                            r_stop_pend,  n_stop_pend;
    logic [4:0]                      r_tx_index,   n_tx_index;
    logic [4:0]                      r_tx_length,  n_tx_length;
    logic                            r_line,       n_line;
    logic [7:0]                      r_rx_shift,   n_rx_shift;
    logic [3:0]                      r_rx_bits,    n_rx_bits;
    logic [7:0]                      r_rx_last,    n_rx_last;
    logic                            n_rx_valid;

    logic              in_fire;
    logic              b_fire;
    logic              due;
    logic              fall_edge;
    logic [4:0]        next_index;
    logic              store_we;
    logic [ADDR_W-1:0] store_raddr;

    // handshake: the update stage moves when the output register is free
    assign b_fire     = r_a_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !b_fire;
    assign in_fire    = i_in_valid && !o_in_stall;

    // buffer writes land at accept; reads look ahead at the committed index
    assign store_we = in_fire && (i_in_word.action == hduart_pkg::ACT_WRITE)
                      && (32'(i_in_word.buf_index) < BUFFER_DEPTH);
    assign store_raddr = (i_in_word.action == hduart_pkg::ACT_SEND) ? '0
                         : ADDR_W'(n_tx_index) + ADDR_W'(1);

    hduart_store #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (ADDR_W'(i_in_word.buf_index)),
        .i_wdata (i_in_word.buf_data),
        .i_re    (in_fire),
        .i_raddr (store_raddr),
        .o_rdata (rd_data)
    );

    // timer and edge detect for the word in the update stage
    assign due        = (r_tick <= hduart_pkg::PERIOD_W'(1));
    assign fall_edge  = r_prev_rx && !r_a_word.rx_level;
    assign next_index = r_tx_index + 5'd1;

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_tick      = r_tick;
        n_prev_rx   = r_prev_rx;
        n_tx_shift  = r_tx_shift;
        n_tx_bits   = r_tx_bits;
        n_stop_pend = r_stop_pend;
        n_tx_index  = r_tx_index;
        n_tx_length = r_tx_length;
        n_line      = r_line;
        n_rx_shift  = r_rx_shift;
        n_rx_bits   = r_rx_bits;
        n_rx_last   = r_rx_last;
        n_rx_valid  = 1'b0;
        if (b_fire) begin
            unique case (r_a_word.action)
                hduart_pkg::ACT_SEND: begin
                    if (r_mode == MODE_IDLE && r_a_word.send_count != 5'd0) begin
                        n_mode      = MODE_TX;
                        n_line      = 1'b0;
                        n_tick      = r_bit_period;
                        n_tx_bits   = hduart_pkg::DATA_BITS;
                        n_stop_pend = 1'b1;
                        n_tx_shift  = rd_data;
                        n_tx_index  = 5'd0;
                        n_tx_length = (32'(r_a_word.send_count) > BUFFER_DEPTH)
                                      ? LEN_MAX : r_a_word.send_count;
                    end
                end
                hduart_pkg::ACT_TICK: begin
                    n_prev_rx = r_a_word.rx_level;
                    if (r_mode != MODE_RX && fall_edge) begin
                        // start edge wins and drops any burst
                        n_mode      = MODE_RX;
                        n_line      = 1'b1;
                        n_tx_bits   = 4'd0;
                        n_stop_pend = 1'b0;
                        n_tx_index  = 5'd0;
                        n_tick      = r_first_delay;
                        n_rx_bits   = hduart_pkg::DATA_BITS;
                        n_rx_shift  = 8'd0;
                    end else if (r_mode != MODE_IDLE) begin
                        n_tick = due ? r_bit_period : r_tick - hduart_pkg::PERIOD_W'(1);
                        if (due && r_mode == MODE_TX) begin
                            // transmit bit event
                            if (r_tx_bits != 4'd0) begin
                                n_line     = r_tx_shift[0];
                                n_tx_shift = {1'b0, r_tx_shift[7:1]};
                                n_tx_bits  = r_tx_bits - 4'd1;
                            end else if (r_stop_pend) begin
                                n_line      = 1'b1;
                                n_stop_pend = 1'b0;
                            end else if (next_index < r_tx_length) begin
                                n_tx_index  = next_index;
                                n_line      = 1'b0;
                                n_stop_pend = 1'b1;
                                n_tx_bits   = hduart_pkg::DATA_BITS;
                                n_tx_shift  = rd_data;
                            end else begin
                                n_mode     = MODE_IDLE;
                                n_tx_index = 5'd0;
                            end
                        end else if (due) begin
                            // receive sample event
                            if (r_rx_bits != 4'd0) begin
                                n_rx_shift = {r_a_word.rx_level, r_rx_shift[7:1]};
                                n_rx_bits  = r_rx_bits - 4'd1;
                            end else begin
                                n_mode     = MODE_IDLE;
                                n_rx_last  = r_rx_shift;
                                n_rx_valid = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= hduart_pkg::BIT_PERIOD_RST;
            r_first_delay <= hduart_pkg::FIRST_SAMPLE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == hduart_pkg::CFG_BIT_PERIOD) begin
                r_bit_period <= i_cfg_data;
            end
            if (i_cfg_index == hduart_pkg::CFG_FIRST_SAMPLE) begin
                r_first_delay <= i_cfg_data;
            end
        end
    end

    // read stage word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (b_fire) begin
            r_a_valid <= 1'b0;
        end
        if (in_fire) begin
            r_a_word <= i_in_word;
        end
    end

    // port state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_tick      <= '0;
            r_prev_rx   <= 1'b1;
            r_tx_shift  <= 8'd0;
            r_tx_bits   <= 4'd0;
            r_stop_pend <= 1'b0;
            r_tx_index  <= 5'd0;
            r_tx_length <= 5'd0;
            r_line      <= 1'b1;
            r_rx_shift  <= 8'd0;
            r_rx_bits   <= 4'd0;
            r_rx_last   <= 8'd0;
            o_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_tick      <= n_tick;
            r_prev_rx   <= n_prev_rx;
            r_tx_shift  <= n_tx_shift;
            r_tx_bits   <= n_tx_bits;
            r_stop_pend <= n_stop_pend;
            r_tx_index  <= n_tx_index;
            r_tx_length <= n_tx_length;
            r_line      <= n_line;
            r_rx_shift  <= n_rx_shift;
            r_rx_bits   <= n_rx_bits;
            r_rx_last   <= n_rx_last;
            if (b_fire) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
        if (b_fire) begin
            o_out_word.tx_line  <= n_line;
            o_out_word.rx_valid <= n_rx_valid;
            o_out_word.rx_data  <= n_rx_last;
            o_out_word.tx_busy  <= (n_mode == MODE_TX);
            o_out_word.rx_busy  <= (n_mode == MODE_RX);
        end
    end

endmodule

`default_nettype wire

/* test/tb_half_duplex_uart_8n1_core.sv */
// testbench for half_duplex_uart_8n1_core: a word-level port model predicts every result word
// random serial frames, bursts and register settings drive it; depends on hduart_pkg and the core
`default_nettype none

module tb_half_duplex_uart_8n1_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_SLOTS     = 16;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {
        PORT_IDLE = 2'd0,
        PORT_TX   = 2'd1,
        PORT_RX   = 2'd2
    } t_port_mode;

    // port model and result queue
    class uart_result_board;
        logic [hduart_pkg::PERIOD_W-1:0] period_ticks;
        logic [hduart_pkg::PERIOD_W-1:0] first_delay;
        t_port_mode                      state;
        logic [hduart_pkg::PERIOD_W-1:0] tick_cnt;
        logic                            line_prev;
        logic [7:0]                      store [BUF_SLOTS];
        logic [7:0]                      tx_sr;
        logic [3:0]                      tx_left;
        logic                            stop_due;
        logic [4:0]                      tx_pos;
        logic [4:0]                      tx_len;
        logic                            line_q;
        logic [7:0]                      rx_sr;
        logic [3:0]                      rx_left;
        logic [7:0]                      rx_byte;
        hduart_pkg::t_out_word           expected_words [$];
        int                              failures;

        function new();
            period_ticks = hduart_pkg::BIT_PERIOD_RST;
            first_delay  = hduart_pkg::FIRST_SAMPLE_RST;
            state        = PORT_IDLE;
            tick_cnt     = '0;
            line_prev    = 1'b1;
            foreach (store[i]) store[i] = '0;
            tx_sr        = '0;
            tx_left      = '0;
            stop_due     = 1'b0;
            tx_pos       = '0;
            tx_len       = '0;
            line_q       = 1'b1;
            rx_sr        = '0;
            rx_left      = '0;
            rx_byte      = '0;
            failures     = 0;
        endfunction

        function void set_reg(logic [hduart_pkg::CFG_IDX_W-1:0] idx,
                              logic [hduart_pkg::PERIOD_W-1:0] val);
            if (idx == hduart_pkg::CFG_BIT_PERIOD) period_ticks = val;
            else first_delay = val;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function bit port_busy();
            return state != PORT_IDLE;
        endfunction

        // counts down one tick, reloads and reports when a bit event is due
        function bit timer_due();
            if (tick_cnt <= 1) begin
                tick_cnt = period_ticks;
                return 1'b1;
            end
            tick_cnt = tick_cnt - 1'b1;
            return 1'b0;
        endfunction

        // one bit time of the transmitter: data, stop, next byte or end of burst
        function void tx_bit_event();
            if (tx_left != 0) begin
                line_q  = tx_sr[0];
                tx_sr   = {1'b0, tx_sr[7:1]};
                tx_left = tx_left - 1'b1;
            end else if (stop_due) begin
                line_q   = 1'b1;
                stop_due = 1'b0;
            end else begin
                tx_pos = tx_pos + 1'b1;
                if (tx_pos < tx_len) begin
                    line_q   = 1'b0;
                    stop_due = 1'b1;
                    tx_left  = hduart_pkg::DATA_BITS;
                    tx_sr    = (tx_pos < BUF_SLOTS) ? store[tx_pos[3:0]] : 8'h00;
                end else begin
                    state  = PORT_IDLE;
                    tx_pos = '0;
                end
            end
        endfunction

        // applies one accepted input word and queues the result it gives
        function void note_word(hduart_pkg::t_in_word w);
            hduart_pkg::t_out_word res;
            logic                  got_byte;
            logic                  fall;
            got_byte = 1'b0;
            case (w.action)
                hduart_pkg::ACT_WRITE: begin
                    store[w.buf_index] = w.buf_data;
                end
                hduart_pkg::ACT_SEND: begin
                    if (state == PORT_IDLE && w.send_count != 0) begin
                        state    = PORT_TX;
                        line_q   = 1'b0;
                        tick_cnt = period_ticks;
                        tx_left  = hduart_pkg::DATA_BITS;
                        stop_due = 1'b1;
                        tx_sr    = store[0];
                        tx_pos   = '0;
                        tx_len   = (w.send_count > BUF_SLOTS) ? 5'(BUF_SLOTS) : w.send_count;
                    end
                end
                hduart_pkg::ACT_TICK: begin
                    fall      = line_prev && !w.rx_level;
                    line_prev = w.rx_level;
                    if (state != PORT_RX && fall) begin
                        // start edge wins over a due timer and drops any burst
                        state    = PORT_RX;
                        line_q   = 1'b1;
                        tx_left  = '0;
                        stop_due = 1'b0;
                        tx_pos   = '0;
                        tick_cnt = first_delay;
                        rx_left  = hduart_pkg::DATA_BITS;
                        rx_sr    = '0;
                    end else if (state == PORT_TX) begin
                        if (timer_due()) tx_bit_event();
                    end else if (state == PORT_RX) begin
                        if (timer_due()) begin
                            if (rx_left != 0) begin
                                rx_sr   = {w.rx_level, rx_sr[7:1]};
                                rx_left = rx_left - 1'b1;
                            end else begin
                                state    = PORT_IDLE;
                                rx_byte  = rx_sr;
                                got_byte = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            res.tx_line  = line_q;
            res.rx_valid = got_byte;
            res.rx_data  = rx_byte;
            res.tx_busy  = (state == PORT_TX);
            res.rx_busy  = (state == PORT_RX);
            expected_words.push_back(res);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        // compares an accepted result word with the oldest expectation
        function void check_word(hduart_pkg::t_out_word got);
            hduart_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                $error("result word with no expectation waiting");
                failures++;
                return;
            end
            want = expected_words.pop_front();
            match_field("tx_line", 8'(want.tx_line), 8'(got.tx_line));
            match_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            match_field("rx_data", want.rx_data, got.rx_data);
            match_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
            match_field("rx_busy", 8'(want.rx_busy), 8'(got.rx_busy));
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    hduart_pkg::t_in_word             in_word;
    logic                             out_valid;
    logic                             out_stall;
    hduart_pkg::t_out_word            out_word;
    logic                             cfg_we;
    logic [hduart_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hduart_pkg::PERIOD_W-1:0]  cfg_data;

    uart_result_board      sb;
    int                    in_calm;
    int                    out_calm;

    // remote sender on the receive line
    logic                  line_bits [$];
    logic                  line_now;
    int                    line_hold;
    int                    line_ticks;

    half_duplex_uart_8n1_core #(
        .BUFFER_DEPTH(BUF_SLOTS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // wait draw with occasional stretches of no idling
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    // next receive line level: framed bytes with idle gaps and rare glitches
    function automatic logic next_line_level();
        logic [7:0] frame_byte;
        logic       lvl;
        if (line_hold == 0) begin
            if (line_bits.size() == 0) begin
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(20, 40)) line_bits.push_back(1'b1);
                else
                    repeat ($urandom_range(1, 3)) line_bits.push_back(1'b1);
                line_bits.push_back(1'b0);
                frame_byte = 8'($urandom);
                for (int i = 0; i < 8; i++) line_bits.push_back(frame_byte[i]);
                line_bits.push_back(1'b1);
            end
            line_now  = line_bits.pop_front();
            line_hold = line_ticks;
        end
        line_hold--;
        lvl = line_now;
        if ($urandom_range(0, 49) == 0) lvl = ~lvl;
        return lvl;
    endfunction

    function automatic hduart_pkg::t_in_word make_word(hduart_pkg::t_action act,
                                                       logic [3:0] idx, logic [7:0] data,
                                                       logic [4:0] cnt, logic lvl);
        hduart_pkg::t_in_word w;
        w.action     = act;
        w.buf_index  = idx;
        w.buf_data   = data;
        w.send_count = cnt;
        w.rx_level   = lvl;
        return w;
    endfunction

    // random word: mostly ticks carrying the remote frames, some writes, sends and no-ops
    function automatic hduart_pkg::t_in_word random_word();
        hduart_pkg::t_in_word w;
        int                   pick;
        w = make_word(hduart_pkg::ACT_TICK, 4'($urandom), 8'($urandom), 5'($urandom),
                      1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            w.action = hduart_pkg::ACT_WRITE;
        end else if (pick < 18) begin
            w.action     = hduart_pkg::ACT_SEND;
            w.send_count = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(1, 3))
                                                       : 5'($urandom_range(0, 31));
        end else if (pick < 20) begin
            w.action = hduart_pkg::ACT_NONE;
        end else begin
            w.rx_level = next_line_level();
        end
        return w;
    endfunction

    // offer one input word and wait until it is taken
    task automatic push_word(input hduart_pkg::t_in_word w);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic random_run(input int n);
        line_bits.delete();
        line_hold  = 0;
        line_ticks = (sb.period_ticks < 2) ? 1 : int'(sb.period_ticks);
        repeat (n) push_word(random_word());
    endtask

    // stop offering, let every result arrive and the pipe empty out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [hduart_pkg::PERIOD_W-1:0] period,
                              input logic [hduart_pkg::PERIOD_W-1:0] delay);
        cfg_we    <= 1'b1;
        cfg_index <= hduart_pkg::CFG_BIT_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_index <= hduart_pkg::CFG_FIRST_SAMPLE;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(hduart_pkg::CFG_BIT_PERIOD, period);
        sb.set_reg(hduart_pkg::CFG_FIRST_SAMPLE, delay);
    endtask

    // result side: after a taken word, sometimes stall for a drawn wait
    initial begin
        int hold;
        hold = 0;
        out_calm = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                if (hold == 0) out_stall <= 1'b0;
            end else if (rst_n && out_valid && !out_stall) begin
                hold = draw_wait(out_calm);
                if (hold > 0) out_stall <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial begin
        logic [hduart_pkg::PERIOD_W-1:0] ph_period [6];
        logic [hduart_pkg::PERIOD_W-1:0] ph_delay [6];
        int                              ph_items [6];
        logic [7:0]                      fill;
        ph_period = '{10'd1, 10'd3, 10'd1023, 10'd0, 10'd7, 10'd2};
        ph_delay  = '{10'd1, 10'd4, 10'd1023, 10'd0, 10'd10, 10'd1023};
        ph_items  = '{80, 80, 30, 60, 80, 40};
        sb = new();
        in_calm = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every buffer slot before any burst, with the data extremes
        for (int i = 0; i < BUF_SLOTS; i++) begin
            fill = (i == 1) ? 8'h00 : (i == BUF_SLOTS - 1) ? 8'hFF : 8'($urandom);
            push_word(make_word(hduart_pkg::ACT_WRITE, 4'(i), fill, 5'($urandom),
                                1'($urandom)));
        end
        random_run(40);

        // fast timing, bring the port to idle with the line high
        drain();
        write_regs(10'd2, 10'd3);
        do push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'h00, 1'b1));
        while (sb.port_busy());

        // directed: ignored actions, clamped burst, edge against a due timer
        push_word(make_word(hduart_pkg::ACT_NONE, 4'hF, 8'hFF, 5'h1F, 1'b0));
        push_word(make_word(hduart_pkg::ACT_SEND, 4'h0, 8'h00, 5'd0, 1'b1));
        push_word(make_word(hduart_pkg::ACT_SEND, 4'hF, 8'hFF, 5'd31, 1'b0));
        push_word(make_word(hduart_pkg::ACT_SEND, 4'h0, 8'h00, 5'd5, 1'b1));
        push_word(make_word(hduart_pkg::ACT_WRITE, 4'hF, 8'h00, 5'd16, 1'b0));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b1));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b1));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b1));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'hF, 8'hFF, 5'h1F, 1'b0));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b0));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b1));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b0));
        push_word(make_word(hduart_pkg::ACT_SEND, 4'h0, 8'h00, 5'd4, 1'b1));
        push_word(make_word(hduart_pkg::ACT_WRITE, 4'hF, 8'hFF, 5'd0, 1'b1));
        push_word(make_word(hduart_pkg::ACT_TICK, 4'h0, 8'h00, 5'd0, 1'b1));
        random_run(100);

        // remaining register settings
        for (int p = 0; p < 6; p++) begin
            drain();
            write_regs(ph_period[p], ph_delay[p]);
            random_run(ph_items[p]);
        end
        drain();

        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/hduart_pkg.sv
sv/hduart_store.sv
sv/half_duplex_uart_8n1_core.sv
test/tb_half_duplex_uart_8n1_core.sv
